[hw/rtl/assert_macros.svh]
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/gpr_pkg.sv]
`default_nettype none
package gpr_pkg;
  localparam int unsigned VramBytes   = 16384;
  localparam int unsigned SpriteCount = 32;
  localparam int unsigned AddrW       = 14;
  localparam logic [13:0] NameTable   = 14'h1800;
  localparam logic [13:0] UpperTable  = 14'h2000;
  localparam int unsigned QueueDepth  = 2;

  // Register indexes of the configuration port.
  localparam logic [2:0] RegBackdrop  = 3'd0;
  localparam logic [2:0] RegColUpper  = 3'd1;
  localparam logic [2:0] RegPatUpper  = 3'd2;
  localparam logic [2:0] RegAttrBase  = 3'd3;
  localparam logic [2:0] RegSprPatBase = 3'd4;

  // One classified command passed from the front to the back.
  typedef struct packed {
    logic        is_query;
    logic [13:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } cmd_t;

  function automatic logic [31:0] palette(input logic [3:0] idx);
    logic [31:0] c;
    case (idx)
      4'd0:  c = 32'h000000ff;
      4'd1:  c = 32'h010101ff;
      4'd2:  c = 32'h3eb849ff;
      4'd3:  c = 32'h74d07dff;
      4'd4:  c = 32'h5955e0ff;
      4'd5:  c = 32'h8076f1ff;
      4'd6:  c = 32'hb95e51ff;
      4'd7:  c = 32'h65dbefff;
      4'd8:  c = 32'hdb6559ff;
      4'd9:  c = 32'hff897dff;
      4'd10: c = 32'hfcc35eff;
      4'd11: c = 32'hded087ff;
      4'd12: c = 32'h3aa241ff;
      4'd13: c = 32'hb766b5ff;
      4'd14: c = 32'hccccccff;
      default: c = 32'hffffffff;
    endcase
    return c;
  endfunction
endpackage
`default_nettype wire

[hw/rtl/gpr_queue.sv]
`default_nettype none
module gpr_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire gpr_pkg::cmd_t in_cmd_i,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output gpr_pkg::cmd_t      out_cmd_o
);
  import gpr_pkg::*;

  cmd_t       mem_q [QueueDepth];
  logic       wptr_q, rptr_q;
  logic [1:0] cnt_q;

  assign in_ready_o  = (cnt_q != 2'(QueueDepth));
  assign out_valid_o = (cnt_q != 2'd0);
  assign out_cmd_o   = mem_q[rptr_q];

  // Two-entry queue between the front and the back.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        wptr_q <= ~wptr_q;
      end
      if (out_valid_o && out_ready_i) begin
        rptr_q <= ~rptr_q;
      end
      cnt_q <= cnt_q + 2'(in_valid_i && in_ready_o) - 2'(out_valid_o && out_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      mem_q[wptr_q] <= in_cmd_i;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/gpr_front.sv]
`default_nettype none
module gpr_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic          kind_i,
  input  wire logic [13:0]   mem_address_i,
  input  wire logic [7:0]    mem_data_i,
  input  wire logic [7:0]    pixel_x_i,
  input  wire logic [7:0]    pixel_y_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_ready_i,
  output gpr_pkg::cmd_t      cmd_o
);
  import gpr_pkg::*;

  logic valid_q;
  cmd_t cmd_q;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  // Input register: classify each transfer as a write or a query.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      cmd_q.is_query    <= kind_i;
      cmd_q.mem_address <= mem_address_i;
      cmd_q.mem_data    <= mem_data_i;
      cmd_q.pixel_x     <= pixel_x_i;
      cmd_q.pixel_y     <= pixel_y_i;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/gpr_back.sv]
`default_nettype none
module gpr_back #(
  parameter int unsigned SPRITE_COUNT = gpr_pkg::SpriteCount
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_ready_o,
  input  wire gpr_pkg::cmd_t cmd_i,
  input  wire logic [3:0]    backdrop_i,
  input  wire logic          col_upper_i,
  input  wire logic          pat_upper_i,
  input  wire logic [13:0]   attr_base_i,
  input  wire logic [13:0]   spr_pat_base_i,
  output logic               clr_busy_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  output logic [3:0]         color_index_o,
  output logic [31:0]        color_rgba_o
);
  import gpr_pkg::*;

  localparam int unsigned SprW = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;

  typedef enum logic [3:0] {
    StClear, StIdle, StName, StPat, StCol, StSy, StSx, StSn, StSc, StSpat, StDone
  } state_e;

  state_e      state_q;
  logic [13:0] clr_q;
  logic [7:0]  vram [VramBytes];
  logic [7:0]  rd_q;
  logic [13:0] raddr;
  logic        rd_en;
  cmd_t        cur_q;
  logic [7:0]  name_q, pat_q, sy_q, sx_q, sn_q;
  logic [3:0]  color_q, sc_q;
  logic [SprW-1:0] spr_q;
  logic        out_valid_q;
  logic [3:0]  out_idx_q;
  logic [31:0] out_rgba_q;

  // Derived pixel fields.
  logic [4:0]  row, col;
  logic [2:0]  line, bitn;
  logic [13:0] third, tile_off, attr_addr;
  logic [7:0]  dy, dx;
  logic        spr_hit;
  logic [13:0] spr_addr;
  logic [3:0]  hi_n, lo_n, bg_color;
  logic        wr_en;
  logic [13:0] waddr;
  logic [7:0]  wdata;

  assign row       = cur_q.pixel_y[7:3];
  assign line      = cur_q.pixel_y[2:0];
  assign col       = cur_q.pixel_x[7:3];
  assign bitn      = 3'd7 - cur_q.pixel_x[2:0];
  assign third     = {1'b0, row[4:3], 11'd0};
  assign tile_off  = third + {3'd0, name_q, 3'd0} + {11'd0, line};
  assign attr_addr = attr_base_i + 14'({spr_q, 2'd0});
  assign dy        = cur_q.pixel_y - sy_q;
  assign dx        = cur_q.pixel_x - sx_q;
  assign spr_hit   = (cur_q.pixel_y < 8'd192) && (cur_q.pixel_y >= sy_q) &&
                     (cur_q.pixel_x >= sx_q) && (dy < 8'd16) && (dx < 8'd16);
  assign spr_addr  = spr_pat_base_i + {3'd0, sn_q, 3'd0} + {10'd0, dy[3:0]} +
                     (dx[3] ? 14'd16 : 14'd0);
  assign hi_n      = (rd_q[7:4] == 4'd0) ? backdrop_i : rd_q[7:4];
  assign lo_n      = (rd_q[3:0] == 4'd0) ? backdrop_i : rd_q[3:0];
  assign bg_color  = pat_q[bitn] ? hi_n : lo_n;

  assign cmd_ready_o   = (state_q == StIdle) && !out_valid_q;
  assign clr_busy_o    = (state_q == StClear);
  assign out_valid_o   = out_valid_q;
  assign color_index_o = out_idx_q;
  assign color_rgba_o  = out_rgba_q;

  // Memory address for the read issued in the current state.
  always_comb begin
    rd_en = 1'b1;
    raddr = 14'd0;
    case (state_q)
      // The name byte is fetched from the command as it is taken.
      StIdle:  raddr = NameTable + {4'd0, cmd_i.pixel_y[7:3], cmd_i.pixel_x[7:3]};
      StName:  raddr = (pat_upper_i ? UpperTable : 14'd0) + third +
                       {3'd0, rd_q, 3'd0} + {11'd0, line};
      StPat:   raddr = (col_upper_i ? UpperTable : 14'd0) + tile_off;
      StCol:   raddr = attr_addr;
      StSy:    raddr = attr_addr + 14'd1;
      StSx:    raddr = attr_addr + 14'd2;
      StSn:    raddr = attr_addr + 14'd3;
      StSc:    raddr = spr_addr;
      // Y byte of the next sprite entry.
      StSpat:  raddr = attr_addr + 14'd4;
      default: rd_en = 1'b0;
    endcase
  end

  // Write port: clearing sweep after reset, or a write command.
  always_comb begin
    wr_en = 1'b0;
    waddr = clr_q;
    wdata = 8'd0;
    if (state_q == StClear) begin
      wr_en = 1'b1;
    end else if (cmd_valid_i && cmd_ready_o && !cmd_i.is_query) begin
      wr_en = 1'b1;
      waddr = cmd_i.mem_address;
      wdata = cmd_i.mem_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      vram[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_q <= vram[raddr];
    end
  end

  // Render sequencer: background fetch then one sprite per five reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      spr_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: begin
          clr_q <= clr_q + 14'd1;
          if (clr_q == 14'(VramBytes - 1)) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (cmd_valid_i && cmd_ready_o && cmd_i.is_query) begin
            cur_q   <= cmd_i;
            state_q <= StName;
          end
        end
        StName: begin
          name_q  <= rd_q;
          state_q <= StPat;
        end
        StPat: begin
          pat_q   <= rd_q;
          state_q <= StCol;
          spr_q   <= '0;
        end
        StCol: begin
          color_q <= bg_color;
          state_q <= StSy;
        end
        StSy: begin
          sy_q    <= rd_q;
          state_q <= StSx;
        end
        StSx: begin
          sx_q    <= rd_q;
          state_q <= StSn;
        end
        StSn: begin
          sn_q    <= rd_q;
          state_q <= StSc;
        end
        StSc: begin
          sc_q    <= rd_q[3:0];
          state_q <= StSpat;
        end
        StSpat: begin
          if (spr_hit && rd_q[3'd7 - dx[2:0]]) begin
            color_q <= sc_q;
          end
          if (spr_q == SprW'(SPRITE_COUNT - 1)) begin
            state_q <= StDone;
          end else begin
            spr_q   <= spr_q + SprW'(1);
            state_q <= StSy;
          end
        end
        StDone: begin
          out_valid_q <= 1'b1;
          out_idx_q   <= color_q;
          out_rgba_q  <= palette(color_q);
          state_q     <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

[hw/rtl/graphics2_pixel_render.sv]
// A write passes the front register and the queue and is stored when the back takes it;
// a query takes the same path and then the background fetch and the sprite scan.
// The back takes one query at a time, limited by the single video memory read port and
// by the wait for the result to be taken; writes drain one per cycle while no query renders
// and no result waits.
// Reset: registers take their reset values and a clearing sweep over all 16384 bytes
// zeroes video memory, during which no input item is taken.
`default_nettype none
module graphics2_pixel_render #(
  parameter int unsigned SPRITE_COUNT = gpr_pkg::SpriteCount
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        kind_i,
  input  wire logic [13:0] mem_address_i,
  input  wire logic [7:0]  mem_data_i,
  input  wire logic [7:0]  pixel_x_i,
  input  wire logic [7:0]  pixel_y_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       color_index_o,
  output logic [31:0]      color_rgba_o
);
  import gpr_pkg::*;

  logic [3:0]  backdrop_q;
  logic        col_upper_q, pat_upper_q;
  logic [13:0] attr_base_q, spr_pat_base_q;
  logic        clr_busy, front_ready;
  logic        f_valid, f_ready, q_valid, q_ready;
  cmd_t        f_cmd, q_cmd;
  logic [2:0]  reg_idx;

  assign pready     = 1'b1;
  assign reg_idx    = paddr[4:2];
  assign in_ready_o = front_ready && !clr_busy;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      backdrop_q     <= 4'd0;
      col_upper_q    <= 1'b1;
      pat_upper_q    <= 1'b0;
      attr_base_q    <= 14'h3b00;
      spr_pat_base_q <= 14'h1800;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        RegBackdrop:   backdrop_q     <= pwdata[3:0];
        RegColUpper:   col_upper_q    <= pwdata[0];
        RegPatUpper:   pat_upper_q    <= pwdata[0];
        RegAttrBase:   attr_base_q    <= pwdata[13:0];
        RegSprPatBase: spr_pat_base_q <= pwdata[13:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      RegBackdrop:   prdata = {28'd0, backdrop_q};
      RegColUpper:   prdata = {31'd0, col_upper_q};
      RegPatUpper:   prdata = {31'd0, pat_upper_q};
      RegAttrBase:   prdata = {18'd0, attr_base_q};
      RegSprPatBase: prdata = {18'd0, spr_pat_base_q};
      default:       prdata = 32'd0;
    endcase
  end

  gpr_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i   (in_valid_i && !clr_busy),
    .in_ready_o   (front_ready),
    .kind_i, .mem_address_i, .mem_data_i, .pixel_x_i, .pixel_y_i,
    .cmd_valid_o  (f_valid),
    .cmd_ready_i  (f_ready),
    .cmd_o        (f_cmd)
  );

  gpr_queue u_queue (
    .clk_i, .rst_ni,
    .in_valid_i  (f_valid),
    .in_ready_o  (f_ready),
    .in_cmd_i    (f_cmd),
    .out_valid_o (q_valid),
    .out_ready_i (q_ready),
    .out_cmd_o   (q_cmd)
  );

  gpr_back #(.SPRITE_COUNT(SPRITE_COUNT)) u_back (
    .clk_i, .rst_ni,
    .cmd_valid_i    (q_valid),
    .cmd_ready_o    (q_ready),
    .cmd_i          (q_cmd),
    .backdrop_i     (backdrop_q),
    .col_upper_i    (col_upper_q),
    .pat_upper_i    (pat_upper_q),
    .attr_base_i    (attr_base_q),
    .spr_pat_base_i (spr_pat_base_q),
    .clr_busy_o     (clr_busy),
    .out_valid_o, .out_ready_i, .color_index_o, .color_rgba_o
  );
endmodule
`default_nettype wire

[hw/rtl/gpr_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module gpr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        pready,
  input wire logic        out_valid_o,
  input wire logic        out_ready_i,
  input wire logic [3:0]  color_index_o,
  input wire logic [31:0] color_rgba_o
);
  import gpr_pkg::*;

  `ASSERT_IMPL(a_pready, clk_i, rst_ni, 1'b1, pready, "pready low")
  `ASSERT_IMPL(a_rgba, clk_i, rst_ni, out_valid_o, color_rgba_o == palette(color_index_o), "rgba")
  `ASSERT_NEXT(a_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(color_index_o), "held")
  `ASSERT_NEXT(a_gap, clk_i, rst_ni, out_valid_o && out_ready_i, !out_valid_o, "gap")
endmodule

bind graphics2_pixel_render gpr_checker u_gpr_checker (
  .clk_i, .rst_ni, .pready,
  .out_valid_o, .out_ready_i, .color_index_o, .color_rgba_o
);
`default_nettype wire

[tb/sv/graphics2_pixel_render_test.sv]
`default_nettype none
module graphics2_pixel_render_test;
  timeunit 1ns;
  timeprecision 1ps;
  import gpr_pkg::*;

  localparam logic KindWrite = 1'b0;
  localparam logic KindQuery = 1'b1;
  localparam int   DrainCycles = 200;

  // One input item as the block sees it.
  typedef struct {
    logic        kind;
    logic [13:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } pixel_cmd_t;

  // One rendered pixel.
  typedef struct {
    logic [3:0]  color_index;
    logic [31:0] color_rgba;
  } pixel_out_t;

  // Directed rows: a command, and a typed expectation where one is given.
  typedef struct {
    pixel_cmd_t cmd;
    logic       typed;
    logic [3:0] color_index;
  } directed_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        kind_i = 1'b0;
  logic [13:0] mem_address_i = '0;
  logic [7:0]  mem_data_i = '0;
  logic [7:0]  pixel_x_i = '0;
  logic [7:0]  pixel_y_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [3:0]  color_index_o;
  logic [31:0] color_rgba_o;

  graphics2_pixel_render u_dut (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid_i, .in_ready_o, .kind_i, .mem_address_i, .mem_data_i, .pixel_x_i,
    .pixel_y_i, .out_valid_o, .out_ready_i, .color_index_o, .color_rgba_o
  );

  always #1 clk_i = ~clk_i;

  // Shadow copy of video memory and registers.
  logic [7:0]  vram_shadow [VramBytes];
  logic [3:0]  backdrop_q;
  logic        col_upper_q;
  logic        pat_upper_q;
  logic [13:0] attr_base_q;
  logic [13:0] spr_pat_base_q;
  logic [31:0] rgba_table [16] = '{
    32'h000000ff, 32'h010101ff, 32'h3eb849ff, 32'h74d07dff,
    32'h5955e0ff, 32'h8076f1ff, 32'hb95e51ff, 32'h65dbefff,
    32'hdb6559ff, 32'hff897dff, 32'hfcc35eff, 32'hded087ff,
    32'h3aa241ff, 32'hb766b5ff, 32'hccccccff, 32'hffffffff
  };

  pixel_out_t pixel_q[$];
  int mismatches = 0;
  int burst_left = 0;
  bit hold_request = 1'b0;
  bit hold_done = 1'b0;
  int hold_count = 0;

  function automatic logic [7:0] shadow_rd(int unsigned addr);
    return vram_shadow[addr[13:0]];
  endfunction

  // Background tile lookup followed by the sprite scan; the last covering sprite wins.
  function automatic logic [3:0] render_color(logic [7:0] px, logic [7:0] py);
    int unsigned row, line, third, nm, pat, cl, pbase, cbase;
    int unsigned at, sy, sx, sn, dy, dx, addr;
    logic [3:0] hi, lo, sc, col;
    logic [7:0] b;
    row   = py >> 3;
    line  = py & 7;
    third = (row >> 3) << 11;
    nm    = shadow_rd(32'h1800 + (px >> 3) + (row << 5));
    pbase = pat_upper_q ? 32'h2000 : 0;
    cbase = col_upper_q ? 32'h2000 : 0;
    pat   = shadow_rd(pbase + third + (nm << 3) + line);
    cl    = shadow_rd(cbase + third + (nm << 3) + line);
    hi    = cl[7:4];
    lo    = cl[3:0];
    if (hi == 4'd0) hi = backdrop_q;
    if (lo == 4'd0) lo = backdrop_q;
    col = pat[7 - (px & 7)] ? hi : lo;
    for (int s = 0; s < SpriteCount; s++) begin
      at = attr_base_q + s * 4;
      sy = shadow_rd(at);
      sx = shadow_rd(at + 1);
      sn = shadow_rd(at + 2);
      sc = 4'(shadow_rd(at + 3));
      if (py >= 192 || py < sy || px < sx) continue;
      dy = py - sy;
      dx = px - sx;
      if (dy >= 16 || dx >= 16) continue;
      addr = spr_pat_base_q + (sn << 3) + dy;
      if (dx >= 8) begin
        addr += 16;
        dx -= 8;
      end
      b = shadow_rd(addr);
      if (b[7 - dx]) col = sc;
    end
    return col;
  endfunction

  // Applies an accepted item to the shadow state and queues any pixel it yields.
  task automatic apply_cmd(pixel_cmd_t c, logic typed, logic [3:0] typed_idx);
    pixel_out_t r;
    if (c.kind == KindWrite) begin
      vram_shadow[c.mem_address] = c.mem_data;
    end else begin
      r.color_index = typed ? typed_idx : render_color(c.pixel_x, c.pixel_y);
      r.color_rgba  = rgba_table[r.color_index];
      pixel_q.push_back(r);
    end
  endtask

  // Offers one item in bursts with random gaps, holding it until the transfer.
  task automatic send_cmd(pixel_cmd_t c, logic typed, logic [3:0] typed_idx);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) @(negedge clk_i);
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i    = 1'b1;
    kind_i        = c.kind;
    mem_address_i = c.mem_address;
    mem_data_i    = c.mem_data;
    pixel_x_i     = c.pixel_x;
    pixel_y_i     = c.pixel_y;
    do @(posedge clk_i); while (!in_ready_o);
    apply_cmd(c, typed, typed_idx);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = {idx, 2'b00}; pwdata = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    case (idx)
      RegBackdrop:   backdrop_q = val[3:0];
      RegColUpper:   col_upper_q = val[0];
      RegPatUpper:   pat_upper_q = val[0];
      RegAttrBase:   attr_base_q = val[13:0];
      RegSprPatBase: spr_pat_base_q = val[13:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    wait (pixel_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Random item aimed at the tables in use, or at a pixel that a sprite may cover.
  function automatic pixel_cmd_t random_cmd();
    pixel_cmd_t c;
    int unsigned sel, at;
    c.kind = ($urandom_range(0, 1) == 0) ? KindWrite : KindQuery;
    c.mem_data = 8'($urandom_range(0, 255));
    c.pixel_x = 8'($urandom_range(0, 255));
    c.pixel_y = 8'(($urandom_range(0, 9) == 0) ? $urandom_range(192, 255)
                                                : $urandom_range(0, 191));
    sel = $urandom_range(0, 9);
    if (c.kind == KindWrite) begin
      case (sel)
        0, 1: c.mem_address = 14'(32'h1800 + $urandom_range(0, 767));
        2, 3: c.mem_address = 14'((pat_upper_q ? 32'h2000 : 32'h0) + $urandom_range(0, 6143));
        4, 5: c.mem_address = 14'((col_upper_q ? 32'h2000 : 32'h0) + $urandom_range(0, 6143));
        6, 7: c.mem_address = 14'(attr_base_q + $urandom_range(0, 127));
        8:    c.mem_address = 14'(spr_pat_base_q + $urandom_range(0, 2047));
        default: c.mem_address = 14'($urandom_range(0, 16383));
      endcase
    end else begin
      c.mem_address = 14'($urandom_range(0, 16383));
      if (sel < 6) begin
        at = attr_base_q + $urandom_range(0, SpriteCount - 1) * 4;
        c.pixel_y = 8'(shadow_rd(at) + $urandom_range(0, 16));
        c.pixel_x = 8'(shadow_rd(at + 1) + $urandom_range(0, 16));
      end
    end
    return c;
  endfunction

  // Result checker against the oldest expectation.
  always @(posedge clk_i) begin
    pixel_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected pixel idx=%0d rgba=%h",
                                       color_index_o, color_rgba_o);
      end else begin
        e = pixel_q.pop_front();
        if (e.color_index !== color_index_o || e.color_rgba !== color_rgba_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected idx=%0d rgba=%h, got idx=%0d rgba=%h",
                     e.color_index, e.color_rgba, color_index_o, color_rgba_o);
        end
      end
    end
  end

  // Receiver stalls at random, with one long hold-off on request.
  always @(negedge clk_i) begin
    if (hold_request && !hold_done) begin
      hold_count++;
      if (hold_count >= 2000) hold_done <= 1'b1;
      out_ready_i <= 1'b0;
    end else if ($urandom_range(0, 15) < 4) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    #1_000_000;
    $display("graphics2_pixel_render: mismatch");
    $finish;
  end

  initial begin
    directed_row_t rows[$];
    directed_row_t d;
    pixel_cmd_t c;
    for (int i = 0; i < VramBytes; i++) vram_shadow[i] = 8'h00;
    backdrop_q = 4'd0; col_upper_q = 1'b1; pat_upper_q = 1'b0;
    attr_base_q = 14'h3b00; spr_pat_base_q = 14'h1800;

    // Directed table: cleared memory first, then tile, sprite and edge cases.
    d.typed = 1'b1; d.color_index = 4'd0;
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd0, 8'd0};        rows.push_back(d);
    d.cmd = '{KindQuery, 14'h3fff, 8'hff, 8'd255, 8'd191}; rows.push_back(d);
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd255, 8'd255};    rows.push_back(d);
    d.typed = 1'b0;
    d.cmd = '{KindWrite, 14'h1800, 8'h01, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindWrite, 14'h0008, 8'haa, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindWrite, 14'h2008, 8'h50, 8'd0, 8'd0};     rows.push_back(d);
    // Set pattern bit picks the high nibble, clear bit the backdrop.
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd0, 8'd0};        rows.push_back(d);
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd1, 8'd0};        rows.push_back(d);
    // All sprites sit at the origin; colour 0 is drawn opaque.
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd7, 8'd0};        rows.push_back(d);
    d.cmd = '{KindWrite, 14'h3b7f, 8'hf9, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindWrite, 14'h3b07, 8'h05, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd7, 8'd0};        rows.push_back(d);
    // Rows at and below the bottom edge, and a sprite reaching past it.
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd7, 8'd192};      rows.push_back(d);
    d.cmd = '{KindWrite, 14'h3b7c, 8'hb8, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindWrite, 14'h3b7d, 8'hf8, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindWrite, 14'h1818, 8'hff, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd255, 8'd191};    rows.push_back(d);
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd255, 8'd200};    rows.push_back(d);
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd248, 8'd184};    rows.push_back(d);
    d.cmd = '{KindWrite, 14'h3fff, 8'h7e, 8'd0, 8'd0};     rows.push_back(d);
    d.cmd = '{KindQuery, 14'h0, 8'h00, 8'd128, 8'd100};    rows.push_back(d);

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].color_index);
    wait_idle();

    // Random phases over several register settings, extremes included.
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          reg_write(RegBackdrop, 32'd15); reg_write(RegColUpper, 32'd0);
          reg_write(RegPatUpper, 32'd1);  reg_write(RegAttrBase, 32'h3ff0);
          reg_write(RegSprPatBase, 32'h3fff);
        end
        1: begin
          reg_write(RegBackdrop, 32'd0);  reg_write(RegColUpper, 32'd1);
          reg_write(RegPatUpper, 32'd1);  reg_write(RegAttrBase, 32'h0);
          reg_write(RegSprPatBase, 32'h0);
        end
        2: begin
          reg_write(RegBackdrop, $urandom_range(1, 14));
          reg_write(RegColUpper, 32'd0);  reg_write(RegPatUpper, 32'd0);
          reg_write(RegAttrBase, $urandom_range(0, 16383));
          reg_write(RegSprPatBase, $urandom_range(0, 16383));
        end
        default: begin
          reg_write(RegBackdrop, $urandom);   reg_write(RegColUpper, $urandom);
          reg_write(RegPatUpper, $urandom);   reg_write(RegAttrBase, 32'h3b00);
          reg_write(RegSprPatBase, 32'h1800);
        end
      endcase
      for (int n = 0; n < 100; n++) begin
        if (ph == 1 && n == 30) hold_request = 1'b1;
        c = random_cmd();
        send_cmd(c, 1'b0, 4'd0);
      end
      wait_idle();
    end

    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("graphics2_pixel_render: match");
    end else begin
      $display("graphics2_pixel_render: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire
